[rtl/lmph_pkg.sv]
// Package for the level meter with peak hold.
// Holds shared constants, register index codes and the per-channel state type.
// No dependencies; the ballistics unit and the top level use it by scoped names.
package lmph_pkg;

  localparam int NUM_BANDS = 8;
  localparam int NUM_CH    = NUM_BANDS + 2;
  localparam int CH_IDX_W  = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;

  localparam int CH_W    = 4;
  localparam int LEVEL_W = 8;
  localparam int HOLD_W  = 4;
  localparam int STEP_W  = 8;
  localparam int CFG_W   = 2;

  localparam logic [HOLD_W-1:0] PEAK_HOLD_TICKS_RST  = 4'd8;
  localparam logic [STEP_W-1:0] PEAK_FALL_STEP_RST   = 8'd3;
  localparam logic [STEP_W-1:0] MIN_RELEASE_STEP_RST = 8'd4;

  localparam logic [CFG_W-1:0] CFG_PEAK_HOLD_TICKS  = 2'd0;
  localparam logic [CFG_W-1:0] CFG_PEAK_FALL_STEP   = 2'd1;
  localparam logic [CFG_W-1:0] CFG_MIN_RELEASE_STEP = 2'd2;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] peak;
    logic [HOLD_W-1:0]  hold;
  } chan_state_t;

  typedef struct packed {
    logic [HOLD_W-1:0] peak_hold_ticks;
    logic [STEP_W-1:0] peak_fall_step;
    logic [STEP_W-1:0] min_release_step;
  } cfg_t;

endpackage

[rtl/lmph_ballistics.sv]
// Combinational level release and peak hold update for one channel.
// Depends on lmph_pkg for the state and configuration types.
module lmph_ballistics (
  input  lmph_pkg::chan_state_t          cur,
  input  logic [lmph_pkg::LEVEL_W-1:0]   target,
  input  lmph_pkg::cfg_t                 cfg,
  output lmph_pkg::chan_state_t          nxt,
  output logic                           changed
);

  logic [lmph_pkg::LEVEL_W-1:0] gap;
  logic [lmph_pkg::LEVEL_W-1:0] half_gap;
  logic [lmph_pkg::LEVEL_W-1:0] step;
  logic [lmph_pkg::LEVEL_W-1:0] new_level;

  // The level rises straight to a higher target; otherwise it falls by the larger
  // of half the gap and the minimum step, but never below the target.
  always_comb begin
    gap      = cur.level - target;
    half_gap = gap >> 1;
    step     = (half_gap < cfg.min_release_step) ? cfg.min_release_step : half_gap;
    if (target >= cur.level) begin
      new_level = target;
    end else if (step >= gap) begin
      new_level = target;
    end else begin
      new_level = cur.level - step;
    end
  end

  always_comb begin
    nxt.level = new_level;
    nxt.peak  = cur.peak;
    nxt.hold  = cur.hold;
    if (new_level >= cur.peak) begin
      nxt.peak = new_level;
      nxt.hold = cfg.peak_hold_ticks;
    end else if (cur.hold != '0) begin
      nxt.hold = cur.hold - lmph_pkg::HOLD_W'(1);
    end else if (cur.peak > cfg.peak_fall_step) begin
      nxt.peak = cur.peak - cfg.peak_fall_step;
    end else begin
      nxt.peak = '0;
    end
    changed = (nxt.level != cur.level) || (nxt.peak != cur.peak);
  end

endmodule

[rtl/level_meter_peak_hold.sv]
// Top level of the level meter with peak hold: channel state, handshakes
// and configuration registers. Depends on lmph_pkg and lmph_ballistics.
//
//   port group  direction  handshake             payload
//   in_*        input      in_valid / in_stall   channel, target_level,
//                                                spectrum_valid, frame_end
//   out_*       output     out_valid / out_stall level, peak, channel_changed,
//                                                frame_changed, frame_last
//   cfg_*       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One transaction is accepted per clock while in_stall is low. A transaction
// passes through the input register, loaded on the accepting edge, and then
// the result register, from which its result is handed over. The state
// update and result capture happen in the same edge, so consecutive
// transactions for the same channel see each other's updates without bypass.
// Synchronous active-low reset clears all channel state, the frame change
// accumulator and the valid flags, and loads register defaults.
// A stalled result holds the result register; the input register then holds
// too and in_stall rises, so at most two transactions are ever in flight.
module level_meter_peak_hold (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [lmph_pkg::CH_W-1:0]       in_channel,
  input  logic [lmph_pkg::LEVEL_W-1:0]    in_target_level,
  input  logic                            in_spectrum_valid,
  input  logic                            in_frame_end,

  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [lmph_pkg::LEVEL_W-1:0]    out_level,
  output logic [lmph_pkg::LEVEL_W-1:0]    out_peak,
  output logic                            out_channel_changed,
  output logic                            out_frame_changed,
  output logic                            out_frame_last,

  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lmph_pkg::CFG_W-1:0]      cfg_index,
  input  logic [lmph_pkg::STEP_W-1:0]     cfg_data
);

  // Configuration registers. Writes are always taken; unknown indexes are
  // dropped.
  lmph_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.peak_hold_ticks  <= lmph_pkg::PEAK_HOLD_TICKS_RST;
      cfg_r.peak_fall_step   <= lmph_pkg::PEAK_FALL_STEP_RST;
      cfg_r.min_release_step <= lmph_pkg::MIN_RELEASE_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lmph_pkg::CFG_PEAK_HOLD_TICKS: begin
          cfg_r.peak_hold_ticks <= cfg_data[lmph_pkg::HOLD_W-1:0];
        end
        lmph_pkg::CFG_PEAK_FALL_STEP: begin
          cfg_r.peak_fall_step <= cfg_data;
        end
        lmph_pkg::CFG_MIN_RELEASE_STEP: begin
          cfg_r.min_release_step <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // Input register stage.
  logic                          s1_vld_r;
  logic [lmph_pkg::CH_W-1:0]     s1_channel_r;
  logic [lmph_pkg::LEVEL_W-1:0]  s1_target_r;
  logic                          s1_spec_vld_r;
  logic                          s1_frame_end_r;

  logic out_vld_r;
  logic out_free;
  logic s1_adv;
  logic in_take;

  // The result register can take a new result when it is empty or being
  // drained this cycle; the input register advances into it on the same edge.
  assign out_free = !out_vld_r || !out_stall;
  assign s1_adv   = s1_vld_r && out_free;
  assign in_stall = s1_vld_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_take) begin
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_channel_r   <= in_channel;
      s1_target_r    <= in_target_level;
      s1_spec_vld_r  <= in_spectrum_valid;
      s1_frame_end_r <= in_frame_end;
    end
  end

  // Per-channel state, one entry per band plus left and right.
  lmph_pkg::chan_state_t chan_r [lmph_pkg::NUM_CH];
  logic                  frame_acc_r;
  logic                  frame_acc_nxt;

  logic [lmph_pkg::CH_IDX_W-1:0] ch_idx;
  logic                          ch_in_range;
  logic                          ch_is_band;
  logic [lmph_pkg::LEVEL_W-1:0]  eff_target;
  lmph_pkg::chan_state_t         cur_state;
  lmph_pkg::chan_state_t         new_state;
  logic                          unit_changed;
  logic                          res_changed;
  logic                          res_frame_changed;

  assign ch_idx      = lmph_pkg::CH_IDX_W'(s1_channel_r);
  assign ch_in_range = int'(s1_channel_r) < lmph_pkg::NUM_CH;
  assign ch_is_band  = int'(s1_channel_r) < lmph_pkg::NUM_BANDS;

  // Band targets read as zero while the spectrum is not valid; the stereo
  // channels ignore that flag.
  assign eff_target = (ch_is_band && !s1_spec_vld_r) ? '0 : s1_target_r;
  assign cur_state  = ch_in_range ? chan_r[ch_idx] : '0;

  lmph_ballistics u_ballistics (
    .cur     (cur_state),
    .target  (eff_target),
    .cfg     (cfg_r),
    .nxt     (new_state),
    .changed (unit_changed)
  );

  assign res_changed       = ch_in_range && unit_changed;
  assign res_frame_changed = res_changed || frame_acc_r;
  // The accumulator restarts after the last channel of each frame.
  assign frame_acc_nxt     = s1_frame_end_r ? 1'b0 : res_frame_changed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lmph_pkg::NUM_CH; i++) begin
        chan_r[i] <= '0;
      end
      frame_acc_r <= 1'b0;
    end else if (s1_adv) begin
      if (ch_in_range) begin
        chan_r[ch_idx] <= new_state;
      end
      frame_acc_r <= frame_acc_nxt;
    end
  end

  // Result register. An out-of-range channel reports zero level and peak.
  logic [lmph_pkg::LEVEL_W-1:0] out_level_r;
  logic [lmph_pkg::LEVEL_W-1:0] out_peak_r;
  logic                         out_chg_r;
  logic                         out_fchg_r;
  logic                         out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_level_r <= ch_in_range ? new_state.level : '0;
      out_peak_r  <= ch_in_range ? new_state.peak : '0;
      out_chg_r   <= res_changed;
      out_fchg_r  <= res_frame_changed;
      out_last_r  <= s1_frame_end_r;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_level           = out_level_r;
  assign out_peak            = out_peak_r;
  assign out_channel_changed = out_chg_r;
  assign out_frame_changed   = out_fchg_r;
  assign out_frame_last      = out_last_r;

endmodule

[bench/testbench.sv]
// Self-checking bench for level_meter_peak_hold: directed table, then random frames.
// Predicts every reading in place and compares it field by field on arrival.
// Depends on lmph_pkg and the level_meter_peak_hold RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // One input transaction and one meter reading, laid out as on the ports.
  typedef struct packed {
    logic [lmph_pkg::CH_W-1:0]    channel;
    logic [lmph_pkg::LEVEL_W-1:0] target_level;
    logic                         spectrum_valid;
    logic                         frame_end;
  } meter_in_t;

  typedef struct packed {
    logic [lmph_pkg::LEVEL_W-1:0] level;
    logic [lmph_pkg::LEVEL_W-1:0] peak;
    logic                         channel_changed;
    logic                         frame_changed;
    logic                         frame_last;
  } meter_out_t;

  // A directed row either carries its reading typed in, or leaves it to the predictor.
  typedef struct packed {
    meter_in_t  stim;
    logic       typed;
    meter_out_t want;
  } table_row_t;

  localparam logic       TYPED      = 1'b1;
  localparam logic       PREDICTED  = 1'b0;
  localparam meter_out_t ANY_RESULT = '0;

  // Index 3 decodes to no register; a write there must leave everything alone.
  localparam logic [lmph_pkg::CFG_W-1:0] CFG_SPARE = 2'd3;

  localparam int NUM_DIRECTED = 23;
  localparam int NUM_PHASES   = 6;
  localparam int PHASE_ITEMS  = 100;
  localparam int MAX_REPORTS  = 10;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;

  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [lmph_pkg::CH_W-1:0]     in_channel = '0;
  logic [lmph_pkg::LEVEL_W-1:0]  in_target_level = '0;
  logic                          in_spectrum_valid = 1'b0;
  logic                          in_frame_end = 1'b0;

  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [lmph_pkg::LEVEL_W-1:0]  out_level;
  logic [lmph_pkg::LEVEL_W-1:0]  out_peak;
  logic                          out_channel_changed;
  logic                          out_frame_changed;
  logic                          out_frame_last;

  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [lmph_pkg::CFG_W-1:0]    cfg_index = '0;
  logic [lmph_pkg::STEP_W-1:0]   cfg_data = '0;

  level_meter_peak_hold dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_channel          (in_channel),
    .in_target_level     (in_target_level),
    .in_spectrum_valid   (in_spectrum_valid),
    .in_frame_end        (in_frame_end),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_level           (out_level),
    .out_peak            (out_peak),
    .out_channel_changed (out_channel_changed),
    .out_frame_changed   (out_frame_changed),
    .out_frame_last      (out_frame_last),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // The bench's own copy of the meter state and the three registers.
  logic [lmph_pkg::LEVEL_W-1:0] level_mem [lmph_pkg::NUM_CH];
  logic [lmph_pkg::LEVEL_W-1:0] peak_mem  [lmph_pkg::NUM_CH];
  logic [lmph_pkg::HOLD_W-1:0]  hold_mem  [lmph_pkg::NUM_CH];
  logic                         frame_acc;
  logic [lmph_pkg::HOLD_W-1:0]  hold_ticks_reg  = lmph_pkg::PEAK_HOLD_TICKS_RST;
  logic [lmph_pkg::STEP_W-1:0]  fall_step_reg   = lmph_pkg::PEAK_FALL_STEP_RST;
  logic [lmph_pkg::STEP_W-1:0]  min_release_reg = lmph_pkg::MIN_RELEASE_STEP_RST;

  // Readings predicted for accepted transactions, oldest first.
  meter_out_t pending_readings [$];

  int  mismatches = 0;
  int  items_sent = 0;
  int  stray_items = 0;
  int  frames_sent = 0;
  int  reg_writes = 0;
  // While set, neither side inserts idle cycles or stalls.
  bit  steady = 1'b0;

  // Advances the bench's meter state by one transaction and returns the reading.
  function automatic meter_out_t ballistics_step(meter_in_t it);
    meter_out_t                   r;
    logic [lmph_pkg::LEVEL_W-1:0] tgt;
    logic [lmph_pkg::LEVEL_W-1:0] old_l;
    logic [lmph_pkg::LEVEL_W-1:0] old_p;
    logic [lmph_pkg::LEVEL_W-1:0] gap;
    logic [lmph_pkg::LEVEL_W-1:0] drop;
    logic [lmph_pkg::LEVEL_W-1:0] l;
    logic [lmph_pkg::LEVEL_W-1:0] p;
    r = '0;
    if (it.channel < lmph_pkg::NUM_CH) begin
      // Bands read as silent while the spectrum is not valid; left and right never do.
      tgt = (it.channel < lmph_pkg::NUM_BANDS && !it.spectrum_valid) ? '0 : it.target_level;
      old_l = level_mem[it.channel];
      old_p = peak_mem[it.channel];
      if (tgt >= old_l) begin
        l = tgt;
      end else begin
        // Release by half the gap, but at least the minimum step, and never past the target.
        gap = old_l - tgt;
        drop = gap >> 1;
        if (drop < min_release_reg) drop = min_release_reg;
        l = (drop >= gap) ? tgt : old_l - drop;
      end
      if (l >= old_p) begin
        p = l;
        hold_mem[it.channel] = hold_ticks_reg;
      end else if (hold_mem[it.channel] != 0) begin
        p = old_p;
        hold_mem[it.channel] = hold_mem[it.channel] - lmph_pkg::HOLD_W'(1);
      end else begin
        p = (old_p > fall_step_reg) ? old_p - fall_step_reg : '0;
      end
      level_mem[it.channel] = l;
      peak_mem[it.channel] = p;
      r.level = l;
      r.peak = p;
      r.channel_changed = (l != old_l) || (p != old_p);
    end
    // The frame flag accumulates over the frame and restarts after its last channel.
    r.frame_changed = r.channel_changed || frame_acc;
    r.frame_last = it.frame_end;
    frame_acc = it.frame_end ? 1'b0 : r.frame_changed;
    return r;
  endfunction

  // Drives one transaction, holds it until accepted, then records its reading.
  task automatic send_item(input meter_in_t it, input logic typed,
                           input meter_out_t want);
    meter_out_t predicted;
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_channel <= it.channel;
    in_target_level <= it.target_level;
    in_spectrum_valid <= it.spectrum_valid;
    in_frame_end <= it.frame_end;
    do @(posedge clk); while (in_stall);
    // The predictor runs on every row so that the state stays in step with the block.
    predicted = ballistics_step(it);
    pending_readings.push_back(typed ? want : predicted);
    items_sent++;
    if (it.channel >= lmph_pkg::NUM_CH) stray_items++;
  endtask

  // Lowers valid and waits until every reading in flight has been checked.
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  // One register write; valid stays high for a following write and is lowered by the caller.
  task automatic write_reg(input logic [lmph_pkg::CFG_W-1:0] idx,
                           input logic [lmph_pkg::STEP_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      lmph_pkg::CFG_PEAK_HOLD_TICKS:  hold_ticks_reg = data[lmph_pkg::HOLD_W-1:0];
      lmph_pkg::CFG_PEAK_FALL_STEP:   fall_step_reg = data;
      lmph_pkg::CFG_MIN_RELEASE_STEP: min_release_reg = data;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic report_reading(input string what, input meter_out_t want,
                                input meter_out_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t: %s: level %0d/%0d peak %0d/%0d changed %0b/%0b frame %0b/%0b last %0b/%0b",
               $realtime, what, want.level, got.level, want.peak, got.peak,
               want.channel_changed, got.channel_changed, want.frame_changed,
               got.frame_changed, want.frame_last, got.frame_last);
    end
  endtask

  // The result side stalls about a third of the time, except in the steady stretch.
  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 33);
  end

  // Each reading the block hands over is compared with the oldest prediction.
  always @(posedge clk) begin
    meter_out_t got;
    meter_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_level, out_peak, out_channel_changed, out_frame_changed, out_frame_last};
      if (pending_readings.size() == 0) begin
        report_reading("reading with no transaction behind it (expected/actual)",
                       ANY_RESULT, got);
      end else begin
        want = pending_readings.pop_front();
        if (got !== want) report_reading("reading mismatch (expected/actual)", want, got);
      end
    end
  end

  // Directed rows run at the reset register values. The typed-in readings are the
  // easy ones: the first full-scale hit after reset and the channels outside the range.
  // The rest walk a fast release, a masked band, the one-step gap on the right channel,
  // and a hold that runs out on the left channel until its peak starts to fall.
  table_row_t directed_rows [NUM_DIRECTED] = '{
    {4'd8,  8'd255, 1'b0, 1'b0, TYPED,     8'd255, 8'd255, 1'b1, 1'b1, 1'b0},
    {4'd8,  8'd0,   1'b0, 1'b0, PREDICTED, ANY_RESULT},
    {4'd0,  8'd200, 1'b0, 1'b0, PREDICTED, ANY_RESULT},
    {4'd0,  8'd200, 1'b1, 1'b1, PREDICTED, ANY_RESULT},
    {4'd12, 8'd77,  1'b1, 1'b0, TYPED,     8'd0,   8'd0,   1'b0, 1'b0, 1'b0},
    {4'd15, 8'd255, 1'b1, 1'b1, TYPED,     8'd0,   8'd0,   1'b0, 1'b0, 1'b1},
    {4'd9,  8'd1,   1'b0, 1'b0, PREDICTED, ANY_RESULT},
    {4'd9,  8'd0,   1'b0, 1'b0, PREDICTED, ANY_RESULT},
    {4'd7,  8'd255, 1'b1, 1'b0, PREDICTED, ANY_RESULT},
    {4'd7,  8'd254, 1'b1, 1'b0, PREDICTED, ANY_RESULT},
    {4'd7,  8'd0,   1'b1, 1'b0, PREDICTED, ANY_RESULT},
    {4'd7,  8'd0,   1'b0, 1'b0, PREDICTED, ANY_RESULT},
    {4'd8,  8'd0,   1'b0, 1'b0, PREDICTED, ANY_RESULT},
    {4'd8,  8'd0,   1'b1, 1'b0, PREDICTED, ANY_RESULT},
    {4'd8,  8'd0,   1'b0, 1'b0, PREDICTED, ANY_RESULT},
    {4'd8,  8'd0,   1'b1, 1'b0, PREDICTED, ANY_RESULT},
    {4'd8,  8'd0,   1'b0, 1'b0, PREDICTED, ANY_RESULT},
    {4'd8,  8'd0,   1'b1, 1'b0, PREDICTED, ANY_RESULT},
    {4'd8,  8'd0,   1'b0, 1'b0, PREDICTED, ANY_RESULT},
    {4'd8,  8'd0,   1'b1, 1'b0, PREDICTED, ANY_RESULT},
    {4'd8,  8'd0,   1'b0, 1'b1, PREDICTED, ANY_RESULT},
    {4'd10, 8'd0,   1'b0, 1'b0, PREDICTED, ANY_RESULT},
    {4'd1,  8'd128, 1'b1, 1'b1, PREDICTED, ANY_RESULT}
  };

  initial begin
    meter_in_t it;
    int        sent;
    int        last_ch;
    int        mood;
    logic      frame_sv;
    for (int c = 0; c < lmph_pkg::NUM_CH; c++) begin
      level_mem[c] = '0;
      peak_mem[c] = '0;
      hold_mem[c] = '0;
    end
    frame_acc = 1'b0;

    // Reset is held low from the start and released on a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_item(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
    end

    // Random phases, each under its own register setting. Phase 0 keeps the reset
    // values; the others include both extremes of every register, a zero fall step
    // with a zero release step, and one setting drawn at random. Phase 3 runs with
    // no idle cycles on either side.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph != 0) begin
        drain();
        case (ph)
          1: begin
            write_reg(lmph_pkg::CFG_PEAK_HOLD_TICKS, 8'd0);
            write_reg(lmph_pkg::CFG_PEAK_FALL_STEP, 8'd255);
            write_reg(lmph_pkg::CFG_MIN_RELEASE_STEP, 8'd255);
          end
          2: begin
            write_reg(lmph_pkg::CFG_PEAK_HOLD_TICKS, 8'd15);
            write_reg(lmph_pkg::CFG_PEAK_FALL_STEP, 8'd0);
            write_reg(lmph_pkg::CFG_MIN_RELEASE_STEP, 8'd0);
          end
          3: begin
            write_reg(lmph_pkg::CFG_PEAK_HOLD_TICKS, 8'd2);
            write_reg(lmph_pkg::CFG_PEAK_FALL_STEP, 8'd1);
            write_reg(lmph_pkg::CFG_MIN_RELEASE_STEP, 8'd1);
          end
          4: begin
            write_reg(lmph_pkg::CFG_PEAK_HOLD_TICKS, 8'($urandom_range(0, 15)));
            write_reg(lmph_pkg::CFG_PEAK_FALL_STEP, 8'($urandom_range(0, 255)));
            write_reg(lmph_pkg::CFG_MIN_RELEASE_STEP, 8'($urandom_range(1, 255)));
            write_reg(CFG_SPARE, 8'($urandom_range(0, 255)));
          end
          default: begin
            write_reg(lmph_pkg::CFG_PEAK_HOLD_TICKS, 8'd0);
            write_reg(lmph_pkg::CFG_PEAK_FALL_STEP, 8'd5);
            write_reg(lmph_pkg::CFG_MIN_RELEASE_STEP, 8'd0);
          end
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
      end
      steady = (ph == 3);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // Halfway through the first reconfigured phase the sender waits for the
        // block to empty completely before it carries on.
        if (ph == 1 && sent >= PHASE_ITEMS / 2 &&
            sent < PHASE_ITEMS / 2 + lmph_pkg::NUM_CH) begin
          drain();
          sent = PHASE_ITEMS / 2 + lmph_pkg::NUM_CH;
        end
        if ($urandom_range(0, 99) < 85) begin
          // A frame walks the channels in order and marks its last one. A few are
          // cut short. The mood sets how loud the frame is, so that loud frames
          // followed by quiet ones drive the release, the hold and the peak fall.
          frame_sv = ($urandom_range(0, 99) < 80);
          mood = $urandom_range(0, 99);
          last_ch = ($urandom_range(0, 99) < 10) ?
                    $urandom_range(0, lmph_pkg::NUM_CH - 2) : lmph_pkg::NUM_CH - 1;
          for (int c = 0; c <= last_ch; c++) begin
            it.channel = lmph_pkg::CH_W'(c);
            it.spectrum_valid = frame_sv;
            it.frame_end = (c == last_ch);
            if (mood < 45) it.target_level = 8'($urandom_range(0, 15));
            else if (mood < 70) it.target_level = 8'($urandom_range(0, 255));
            else it.target_level = 8'($urandom_range(160, 255));
            send_item(it, PREDICTED, ANY_RESULT);
            sent++;
          end
          frames_sent++;
        end else begin
          // Noise: any channel code the port can carry, with random flags.
          it.channel = lmph_pkg::CH_W'($urandom_range(0, 15));
          it.target_level = 8'($urandom_range(0, 255));
          it.spectrum_valid = 1'($urandom_range(0, 1));
          it.frame_end = 1'($urandom_range(0, 1));
          send_item(it, PREDICTED, ANY_RESULT);
          sent++;
        end
      end
    end

    drain();
    // Wait on so that any reading the block should not have produced shows up.
    repeat (4) @(posedge clk);

    $display("Sent %0d transactions: %0d complete or cut-short frames, %0d off-range.",
             items_sent, frames_sent, stray_items);
    $display("Used %0d register settings through %0d register writes; %0d mismatched.",
             NUM_PHASES, reg_writes, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: the timeout lies far beyond what the run needs.
  initial begin
    #5ms;
    $display("Timed out with %0d readings still outstanding.", pending_readings.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[sim.f]
rtl/lmph_pkg.sv
rtl/lmph_ballistics.sv
rtl/level_meter_peak_hold.sv
bench/testbench.sv
